// File: rtl/tlce_pkg.sv
// tlce_pkg: shared types and constants for the line-numbering caret-escape filter
// used by tlce_front, tlce_queue, tlce_back and the top level
`default_nettype none

package tlce_pkg;

  // default width of the printed line number
  localparam int unsigned NUMBER_DIGITS = 6;
  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned CFG_IDX_W     = 3;

  // byte codes
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NL        = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_QMARK     = 8'h3F;
  localparam logic [7:0] CH_CAP_I     = 8'h49;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_DEL       = 8'd127;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_ALL       = 3'd0,
    CFG_NUMBER_NONBLANK  = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_ENDS        = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // what goes in front of the body bytes
  typedef enum logic [1:0] {
    PFX_NONE   = 2'd0,
    PFX_NUMBER = 2'd1,
    PFX_BLANK  = 2'd2
  } prefix_e;

  // classified item handed from front to back
  typedef struct packed {
    prefix_e    prefix;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       drop;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/tlce_front.sv
// tlce_front: classifies each accepted text byte and keeps the line state
// (line number digits, blank run, line start); uses tlce_pkg
`default_nettype none

module tlce_front #(
  parameter int unsigned NumDigits = tlce_pkg::NUMBER_DIGITS
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire tlce_pkg::cfg_t        cfg_i,
  input  wire                        accept_i,
  input  wire  [7:0]                 data_byte_i,
  input  wire                        first_of_file_i,
  output tlce_pkg::ctl_t             ctl_o,
  output logic [NumDigits*4-1:0]     digits_o
);

  localparam int unsigned DW = NumDigits * 4;
  localparam logic [DW-1:0] DigitsOne = DW'(1);

  logic [DW-1:0] digits_q, digits_d;
  logic [1:0]    blank_q, blank_d;
  logic          start_q, start_d;

  logic [DW-1:0] digits_cur;
  logic [DW-1:0] digits_inc;
  logic [1:0]    blank_cur;
  logic          start_cur;
  logic          line_empty;
  logic          drop;
  logic          number;
  logic          nonprint;

  assign digits_cur = first_of_file_i ? DigitsOne : digits_q;
  assign blank_cur  = first_of_file_i ? 2'd0 : blank_q;
  assign start_cur  = first_of_file_i | start_q;
  assign line_empty = start_cur && (data_byte_i == tlce_pkg::CH_NL);

  // decimal ripple increment, wraps to zero after all nines
  always_comb begin
    logic carry;
    carry = 1'b1;
    digits_inc = digits_cur;
    for (int i = 0; i < NumDigits; i++) begin
      if (carry) begin
        if (digits_cur[i*4 +: 4] >= 4'd9) begin
          digits_inc[i*4 +: 4] = 4'd0;
        end else begin
          digits_inc[i*4 +: 4] = digits_cur[i*4 +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_comb begin
    blank_d = blank_cur;
    drop    = 1'b0;
    if (start_cur) begin
      if (line_empty) begin
        if (cfg_i.squeeze_blank) begin
          blank_d = (blank_cur == 2'd2) ? 2'd2 : blank_cur + 2'd1;
          drop    = (blank_d == 2'd2);
        end
      end else begin
        blank_d = 2'd0;
      end
    end
  end

  assign number = start_cur && !drop &&
                  ((cfg_i.number_all && !cfg_i.number_nonblank) ||
                   (cfg_i.number_nonblank && !line_empty));

  assign nonprint = cfg_i.show_nonprinting && (data_byte_i != tlce_pkg::CH_NL) &&
                    (data_byte_i != tlce_pkg::CH_TAB) &&
                    ((data_byte_i < tlce_pkg::CH_SPACE) || (data_byte_i == tlce_pkg::CH_DEL));

  always_comb begin
    ctl_o.prefix = number ? tlce_pkg::PFX_NUMBER : tlce_pkg::PFX_NONE;
    ctl_o.byte0  = data_byte_i;
    ctl_o.byte1  = data_byte_i;
    ctl_o.two    = 1'b0;
    ctl_o.drop   = drop;
    if (drop) begin
      ctl_o.byte0 = 8'd0;
    end else if (nonprint) begin
      ctl_o.byte0 = tlce_pkg::CH_CARET;
      ctl_o.byte1 = (data_byte_i == tlce_pkg::CH_DEL) ? tlce_pkg::CH_QMARK
                                                      : data_byte_i + tlce_pkg::CARET_OFFSET;
      ctl_o.two   = 1'b1;
    end else if (cfg_i.show_ends && data_byte_i == tlce_pkg::CH_NL) begin
      if (cfg_i.number_nonblank && line_empty) begin
        ctl_o.prefix = tlce_pkg::PFX_BLANK;
      end
      ctl_o.byte0 = tlce_pkg::CH_DOLLAR;
      ctl_o.byte1 = tlce_pkg::CH_NL;
      ctl_o.two   = 1'b1;
    end else if (cfg_i.show_tabs && data_byte_i == tlce_pkg::CH_TAB) begin
      ctl_o.byte0 = tlce_pkg::CH_CARET;
      ctl_o.byte1 = tlce_pkg::CH_CAP_I;
      ctl_o.two   = 1'b1;
    end
  end

  assign digits_o = digits_cur;
  assign digits_d = number ? digits_inc : digits_cur;
  assign start_d  = (data_byte_i == tlce_pkg::CH_NL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= DigitsOne;
      blank_q  <= 2'd0;
      start_q  <= 1'b1;
    end else if (accept_i) begin
      digits_q <= digits_d;
      blank_q  <= blank_d;
      start_q  <= start_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tlce_queue.sv
// tlce_queue: small register queue between the front and back halves
// depth from tlce_pkg; entries are opaque bit vectors
`default_nettype none

module tlce_queue #(
  parameter int unsigned Width = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [Width-1:0] wdata_i,
  input  wire              pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             not_empty_o
);

  localparam int unsigned Depth = tlce_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o      = (cnt_q == CntFull);
  assign not_empty_o = (cnt_q != '0);
  assign rdata_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tlce_back.sv
// tlce_back: expands the queue head into output bytes, one per cycle while the
// receiver does not stall, through a registered output stage; uses tlce_pkg
`default_nettype none

module tlce_back #(
  parameter int unsigned NumDigits = tlce_pkg::NUMBER_DIGITS
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        head_valid_i,
  input  wire tlce_pkg::ctl_t        head_ctl_i,
  input  wire  [NumDigits*4-1:0]     head_digits_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_o,
  output logic                       none_emitted_o
);

  localparam int unsigned PosW = $clog2(NumDigits + 3);
  localparam logic [PosW-1:0] TabPos   = PosW'(NumDigits);
  localparam logic [PosW-1:0] Body0Pos = PosW'(NumDigits + 1);
  localparam logic [PosW-1:0] Body1Pos = PosW'(NumDigits + 2);

  logic [PosW-1:0] pos_q, pos_d;
  logic            busy_q, busy_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic            none_q, none_d;

  logic [PosW-1:0] pos;
  logic            advance;
  logic            is_last;
  logic [7:0]      digit_byte;

  // position 0 is the most significant digit
  always_comb begin
    logic       lead;
    logic [3:0] d;
    lead       = 1'b1;
    digit_byte = tlce_pkg::CH_SPACE;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      d    = head_digits_i[i*4 +: 4];
      lead = lead && (d == 4'd0) && (i != 0);
      if (pos == PosW'(NumDigits - 1 - i) && head_ctl_i.prefix == tlce_pkg::PFX_NUMBER &&
          !lead) begin
        digit_byte = tlce_pkg::CH_ZERO + {4'd0, d};
      end
    end
  end

  assign pos = busy_q ? pos_q
             : ((head_ctl_i.prefix == tlce_pkg::PFX_NONE) ? Body0Pos : '0);

  assign is_last = head_ctl_i.drop || (pos == Body1Pos) ||
                   (pos == Body0Pos && !head_ctl_i.two);

  assign advance = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o   = advance && is_last;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    none_d  = none_q;
    pos_d   = pos_q;
    busy_d  = busy_q;
    if (advance) begin
      valid_d = 1'b1;
      last_d  = is_last;
      none_d  = head_ctl_i.drop;
      if (pos == Body0Pos) begin
        byte_d = head_ctl_i.byte0;
      end else if (pos == Body1Pos) begin
        byte_d = head_ctl_i.byte1;
      end else if (pos == TabPos) begin
        byte_d = tlce_pkg::CH_TAB;
      end else begin
        byte_d = digit_byte;
      end
      busy_d = !is_last;
      pos_d  = pos + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      busy_q  <= busy_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    none_q <= none_d;
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign last_o         = last_q;
  assign none_emitted_o = none_q;

endmodule

`default_nettype wire

// File: rtl/text_line_number_caret_escape.sv
// text_line_number_caret_escape: top level of the line-numbering caret-escape filter
// instantiates tlce_front, tlce_queue and tlce_back; uses tlce_pkg
//
// Input channel (in_valid_i/in_ready_o) takes one text byte per item with a
// first_of_file flag that restarts the line number and blank run. Output channel
// (out_valid_o/out_ready_i) returns one byte per item, last_o marking the final
// byte of an input's run; a squeezed empty line gives one item with
// none_emitted_o set and out_byte_o zero.
// The front classifies an input in the cycle it is accepted and writes a 4-entry
// queue; the back emits one byte per cycle, unless the receiver stalls, from the
// queue head into an output register. The filter takes one input per cycle while
// each input makes one output byte and the receiver does not stall; an input that
// makes n bytes (up to NumDigits+3) holds the back end until all n are emitted,
// and the queue absorbs such bursts before in_ready_o drops.
// When the receiver stalls the output register holds, the queue fills and
// in_ready_o falls once all entries are taken.
// Reset clears the queue and output stage, sets the line number to one, the
// blank run to zero and marks a line start; all options reset to off.
// Configuration writes (cfg_valid_i/cfg_ready_o) are always taken; index 6 and 7
// are ignored, only cfg_data_i is stored.
`default_nettype none

module text_line_number_caret_escape #(
  parameter int unsigned NumDigits = tlce_pkg::NUMBER_DIGITS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [tlce_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire                               cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [7:0]                        data_byte_i,
  input  wire                               first_of_file_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [7:0]                        out_byte_o,
  output logic                              last_o,
  output logic                              none_emitted_o
);

  localparam int unsigned DW     = NumDigits * 4;
  localparam int unsigned CtlW   = $bits(tlce_pkg::ctl_t);
  localparam int unsigned QWidth = CtlW + DW;

  tlce_pkg::cfg_t cfg_q;

  tlce_pkg::ctl_t front_ctl, head_ctl;
  logic [DW-1:0]  front_digits, head_digits;
  logic [QWidth-1:0] q_rdata;
  logic accept;
  logic q_full, q_not_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tlce_pkg::CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data_i;
        tlce_pkg::CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data_i;
        tlce_pkg::CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data_i;
        tlce_pkg::CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data_i;
        tlce_pkg::CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data_i;
        tlce_pkg::CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  tlce_front #(
    .NumDigits(NumDigits)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .first_of_file_i(first_of_file_i),
    .ctl_o          (front_ctl),
    .digits_o       (front_digits)
  );

  tlce_queue #(
    .Width(QWidth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .wdata_i    ({front_ctl, front_digits}),
    .pop_i      (q_pop),
    .rdata_o    (q_rdata),
    .full_o     (q_full),
    .not_empty_o(q_not_empty)
  );

  assign head_ctl    = tlce_pkg::ctl_t'(q_rdata[QWidth-1 -: CtlW]);
  assign head_digits = q_rdata[DW-1:0];

  tlce_back #(
    .NumDigits(NumDigits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_not_empty),
    .head_ctl_i    (head_ctl),
    .head_digits_i (head_digits),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .none_emitted_o(none_emitted_o)
  );

  // a suppressed line is always a single zero byte ending its run
  a_drop_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_emitted_o |-> last_o && (out_byte_o == 8'd0))
    else $error("suppressed item not a single zero byte");

  // output only comes out of a queued entry
  a_out_from_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(q_not_empty))
    else $error("output appeared with empty queue");

  // an entry is popped only while it is being emitted
  a_pop_with_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o && last_o)
    else $error("queue pop without a final output byte");

endmodule

`default_nettype wire
